// File: rtl/sbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split-read breakpoint check package
// Configuration record, check codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;
    localparam int BOUND_BITS    = 34;
    localparam int GAP_BITS      = 21;
    localparam int EXT_BITS      = 16;
    localparam int MAX_GAP_BITS  = 20;
    localparam int OVL_BITS      = 16;
    localparam int TOL_BITS      = 16;

    localparam logic [1:0] REG_MIN_EXT     = 2'd0;
    localparam logic [1:0] REG_MAX_GAP     = 2'd1;
    localparam logic [1:0] REG_MAX_OVERLAP = 2'd2;
    localparam logic [1:0] REG_TOLERANCE   = 2'd3;

    localparam logic [EXT_BITS-1:0]     RST_MIN_EXT     = 16'd100;
    localparam logic [MAX_GAP_BITS-1:0] RST_MAX_GAP     = 20'd1000;
    localparam logic [OVL_BITS-1:0]     RST_MAX_OVERLAP = 16'd50;
    localparam logic [TOL_BITS-1:0]     RST_TOLERANCE   = 16'd0;

    localparam logic [1:0] CHECK_LEFT_FR  = 2'd0;
    localparam logic [1:0] CHECK_LEFT_RF  = 2'd1;
    localparam logic [1:0] CHECK_RIGHT_FR = 2'd2;
    localparam logic [1:0] CHECK_RIGHT_RF = 2'd3;

    typedef struct packed {
        logic [EXT_BITS-1:0]     min_ext;
        logic [MAX_GAP_BITS-1:0] max_gap;
        logic [OVL_BITS-1:0]     max_overlap;
        logic [TOL_BITS-1:0]     tolerance;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [1:0] index;
    } t_op_ctrl;

endpackage

// File: rtl/sbc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split-read breakpoint check configuration registers
// APB-style register file holding the four check thresholds.
// ----------------------------------------------------------------------------
module sbc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sbc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [sbc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [sbc_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output sbc_pkg::t_cfg                     o_cfg
);

    sbc_pkg::t_cfg r_cfg;
    logic [1:0]    reg_index;

    assign reg_index = paddr[3:2];
    assign pready    = 1'b1;
    assign o_cfg     = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_ext     <= sbc_pkg::RST_MIN_EXT;
            r_cfg.max_gap     <= sbc_pkg::RST_MAX_GAP;
            r_cfg.max_overlap <= sbc_pkg::RST_MAX_OVERLAP;
            r_cfg.tolerance   <= sbc_pkg::RST_TOLERANCE;
        end else if (psel && penable && pwrite) begin
            case (reg_index)
                sbc_pkg::REG_MIN_EXT: begin
                    r_cfg.min_ext <= pwdata[sbc_pkg::EXT_BITS-1:0];
                end
                sbc_pkg::REG_MAX_GAP: begin
                    r_cfg.max_gap <= pwdata[sbc_pkg::MAX_GAP_BITS-1:0];
                end
                sbc_pkg::REG_MAX_OVERLAP: begin
                    r_cfg.max_overlap <= pwdata[sbc_pkg::OVL_BITS-1:0];
                end
                sbc_pkg::REG_TOLERANCE: begin
                    r_cfg.tolerance <= pwdata[sbc_pkg::TOL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            sbc_pkg::REG_MIN_EXT: begin
                prdata = {{(sbc_pkg::CFG_DATA_BITS-sbc_pkg::EXT_BITS){1'b0}},
                          r_cfg.min_ext};
            end
            sbc_pkg::REG_MAX_GAP: begin
                prdata = {{(sbc_pkg::CFG_DATA_BITS-sbc_pkg::MAX_GAP_BITS){1'b0}},
                          r_cfg.max_gap};
            end
            sbc_pkg::REG_MAX_OVERLAP: begin
                prdata = {{(sbc_pkg::CFG_DATA_BITS-sbc_pkg::OVL_BITS){1'b0}},
                          r_cfg.max_overlap};
            end
            sbc_pkg::REG_TOLERANCE: begin
                prdata = {{(sbc_pkg::CFG_DATA_BITS-sbc_pkg::TOL_BITS){1'b0}},
                          r_cfg.tolerance};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// File: rtl/sbc_issue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split-read breakpoint check issue stage
// Holds one alignment pair and issues its four checks, one per cycle while not stalled.
// ----------------------------------------------------------------------------
module sbc_issue #(
    parameter int RB = 32,
    parameter int QB = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_adv,
    input  logic [QB-1:0]       i_query_length,
    input  logic [RB-1:0]       i_fwd_ref_start,
    input  logic [RB-1:0]       i_fwd_ref_end,
    input  logic [QB-1:0]       i_fwd_qry_start,
    input  logic [QB-1:0]       i_fwd_qry_end,
    input  logic [RB-1:0]       i_rev_ref_start,
    input  logic [RB-1:0]       i_rev_ref_end,
    input  logic [QB-1:0]       i_rev_qry_start,
    input  logic [QB-1:0]       i_rev_qry_end,
    output sbc_pkg::t_op_ctrl   o_ctrl,
    output logic [QB-1:0]       o_q,
    output logic [RB-1:0]       o_a_rs,
    output logic [RB-1:0]       o_a_re,
    output logic [QB-1:0]       o_a_qs,
    output logic [QB-1:0]       o_a_qe,
    output logic [RB-1:0]       o_b_rs,
    output logic [RB-1:0]       o_b_re,
    output logic [QB-1:0]       o_b_qs,
    output logic [QB-1:0]       o_b_qe
);

    logic          r_busy;
    logic [1:0]    r_idx;
    logic [QB-1:0] r_q;
    logic [RB-1:0] r_f_rs, r_f_re, r_r_rs, r_r_re;
    logic [QB-1:0] r_f_qs, r_f_qe, r_r_qs, r_r_qe;
    logic          issue_go;
    logic          last_go;
    logic          accept;
    logic          swap;

    assign issue_go = r_busy && i_adv;
    assign last_go  = issue_go && (r_idx == sbc_pkg::CHECK_RIGHT_RF);
    assign o_stall  = r_busy && !last_go;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= sbc_pkg::CHECK_LEFT_FR;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_idx  <= sbc_pkg::CHECK_LEFT_FR;
        end else if (issue_go) begin
            r_idx <= r_idx + 2'd1;
            if (last_go) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q    <= i_query_length;
            r_f_rs <= i_fwd_ref_start;
            r_f_re <= i_fwd_ref_end;
            r_f_qs <= i_fwd_qry_start;
            r_f_qe <= i_fwd_qry_end;
            r_r_rs <= i_rev_ref_start;
            r_r_re <= i_rev_ref_end;
            r_r_qs <= i_rev_qry_start;
            r_r_qe <= i_rev_qry_end;
        end
    end

    assign swap = (r_idx == sbc_pkg::CHECK_LEFT_RF) || (r_idx == sbc_pkg::CHECK_RIGHT_RF);

    assign o_ctrl.valid = r_busy;
    assign o_ctrl.index = r_idx;
    assign o_q          = r_q;
    assign o_a_rs       = swap ? r_r_rs : r_f_rs;
    assign o_a_re       = swap ? r_r_re : r_f_re;
    assign o_a_qs       = swap ? r_r_qs : r_f_qs;
    assign o_a_qe       = swap ? r_r_qe : r_f_qe;
    assign o_b_rs       = swap ? r_f_rs : r_r_rs;
    assign o_b_re       = swap ? r_f_re : r_r_re;
    assign o_b_qs       = swap ? r_f_qs : r_r_qs;
    assign o_b_qe       = swap ? r_f_qe : r_r_qe;

endmodule

// File: rtl/sbc_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split-read breakpoint check pipeline
// Four register stages: operands, overlap and distance, limit checks with
// partial bounds, final tolerance-widened intervals.
// ----------------------------------------------------------------------------
module sbc_pipe #(
    parameter int RB = 32,
    parameter int QB = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  sbc_pkg::t_op_ctrl                 i_ctrl,
    input  sbc_pkg::t_cfg                     i_cfg,
    input  logic [QB-1:0]                     i_q,
    input  logic [RB-1:0]                     i_a_rs,
    input  logic [RB-1:0]                     i_a_re,
    input  logic [QB-1:0]                     i_a_qs,
    input  logic [QB-1:0]                     i_a_qe,
    input  logic [RB-1:0]                     i_b_rs,
    input  logic [RB-1:0]                     i_b_re,
    input  logic [QB-1:0]                     i_b_qs,
    input  logic [QB-1:0]                     i_b_qe,
    output logic                              o_valid,
    output logic [1:0]                        o_check_index,
    output logic                              o_hit,
    output logic [sbc_pkg::BOUND_BITS-1:0]    o_first_low,
    output logic [sbc_pkg::BOUND_BITS-1:0]    o_first_high,
    output logic [sbc_pkg::BOUND_BITS-1:0]    o_second_low,
    output logic [sbc_pkg::BOUND_BITS-1:0]    o_second_high,
    output logic [sbc_pkg::GAP_BITS-1:0]      o_gap,
    output logic                              o_last
);

    localparam int WA = (RB > QB) ? (RB + 3) : (QB + 3);
    localparam int WX = (WA > sbc_pkg::BOUND_BITS) ? WA : sbc_pkg::BOUND_BITS;

    typedef logic signed [WX-1:0] t_w;

    // Stage A: operands of the check.
    logic a_left;
    t_w   a_ra, a_rb, a_p, a_q, a_lena, a_lenb, a_rae;
    t_w   qx, ext_x, mg_x, mo_x, tol_x;

    logic       r_a_v, r_a_left;
    logic [1:0] r_a_idx;
    t_w         r_a_ra, r_a_rb, r_a_p, r_a_q, r_a_lena, r_a_lenb, r_a_rae;

    // Stage B: overlap and distance.
    logic b_ovl;
    t_w   b_d;
    logic b_rej;

    logic       r_b_v, r_b_left, r_b_ovl, r_b_rej;
    logic [1:0] r_b_idx;
    t_w         r_b_d, r_b_ra, r_b_rb, r_b_lena, r_b_lenb, r_b_rae;

    // Stage C: limit checks and partial bounds.
    t_w   c_de;
    logic c_ok_ovl, c_hit, c_sub;
    t_w   c_lo1, c_hi1, c_lo2, c_hi2, c_gap;

    logic                             r_c_v, r_c_hit;
    logic [1:0]                       r_c_idx;
    t_w                               r_c_lo1, r_c_hi1, r_c_lo2, r_c_hi2;
    logic [sbc_pkg::GAP_BITS-1:0]     r_c_gap;

    // Stage D: output register.
    t_w d_lo1, d_hi1, d_lo2, d_hi2;

    logic                             r_d_v, r_d_hit;
    logic [1:0]                       r_d_idx;
    logic [sbc_pkg::BOUND_BITS-1:0]   r_d_lo1, r_d_hi1, r_d_lo2, r_d_hi2;
    logic [sbc_pkg::GAP_BITS-1:0]     r_d_gap;

    assign ext_x = $signed({{(WX-sbc_pkg::EXT_BITS){1'b0}}, i_cfg.min_ext});
    assign mg_x  = $signed({{(WX-sbc_pkg::MAX_GAP_BITS){1'b0}}, i_cfg.max_gap});
    assign mo_x  = $signed({{(WX-sbc_pkg::OVL_BITS){1'b0}}, i_cfg.max_overlap});
    assign tol_x = $signed({{(WX-sbc_pkg::TOL_BITS){1'b0}}, i_cfg.tolerance});
    assign qx    = $signed({{(WX-QB){1'b0}}, i_q});

    always_comb begin
        a_left = (i_ctrl.index == sbc_pkg::CHECK_LEFT_FR) ||
                 (i_ctrl.index == sbc_pkg::CHECK_LEFT_RF);
        if (a_left) begin
            a_ra = $signed({{(WX-RB){1'b0}}, i_a_re});
            a_rb = $signed({{(WX-RB){1'b0}}, i_b_re});
            a_p  = $signed({{(WX-QB){1'b0}}, i_a_qe});
            a_q  = qx - $signed({{(WX-QB){1'b0}}, i_b_qe});
        end else begin
            a_ra = $signed({{(WX-RB){1'b0}}, i_a_rs});
            a_rb = $signed({{(WX-RB){1'b0}}, i_b_rs});
            a_p  = qx - $signed({{(WX-QB){1'b0}}, i_b_qs});
            a_q  = $signed({{(WX-QB){1'b0}}, i_a_qs});
        end
        a_lena = $signed({{(WX-QB){1'b0}}, i_a_qe}) - $signed({{(WX-QB){1'b0}}, i_a_qs});
        a_lenb = $signed({{(WX-QB){1'b0}}, i_b_qe}) - $signed({{(WX-QB){1'b0}}, i_b_qs});
        a_rae  = a_ra + ext_x;
    end

    always_comb begin
        b_ovl = r_a_p > r_a_q;
        b_d   = b_ovl ? (r_a_p - r_a_q) : (r_a_q - r_a_p);
        b_rej = (r_a_rae > r_a_rb) || ((r_a_p + mg_x) < r_a_q);
    end

    // The side that moves by the distance depends on the check direction
    // and on whether the pieces overlap on the read.
    always_comb begin
        c_de     = r_b_d + ext_x;
        c_ok_ovl = (r_b_lena >= c_de) && (r_b_lenb >= c_de) &&
                   !((r_b_rae + r_b_d) > r_b_rb) && (r_b_d <= mo_x);
        c_hit    = !r_b_rej && (!r_b_ovl || c_ok_ovl);
        c_sub    = r_b_left ? r_b_ovl : !r_b_ovl;
        c_lo1    = c_sub ? (r_b_ra - r_b_d) : r_b_ra;
        c_hi1    = c_sub ? r_b_ra : (r_b_ra + r_b_d);
        c_lo2    = c_sub ? (r_b_rb - r_b_d) : r_b_rb;
        c_hi2    = c_sub ? r_b_rb : (r_b_rb + r_b_d);
        c_gap    = r_b_ovl ? (t_w'(0) - r_b_d) : r_b_d;
    end

    always_comb begin
        d_lo1 = r_c_lo1 - tol_x;
        d_hi1 = r_c_hi1 + tol_x;
        d_lo2 = r_c_lo2 - tol_x;
        d_hi2 = r_c_hi2 + tol_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (i_adv) begin
            r_a_v <= i_ctrl.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_left <= a_left;
            r_a_idx  <= i_ctrl.index;
            r_a_ra   <= a_ra;
            r_a_rb   <= a_rb;
            r_a_p    <= a_p;
            r_a_q    <= a_q;
            r_a_lena <= a_lena;
            r_a_lenb <= a_lenb;
            r_a_rae  <= a_rae;

            r_b_left <= r_a_left;
            r_b_idx  <= r_a_idx;
            r_b_ovl  <= b_ovl;
            r_b_rej  <= b_rej;
            r_b_d    <= b_d;
            r_b_ra   <= r_a_ra;
            r_b_rb   <= r_a_rb;
            r_b_lena <= r_a_lena;
            r_b_lenb <= r_a_lenb;
            r_b_rae  <= r_a_rae;

            r_c_idx <= r_b_idx;
            r_c_hit <= c_hit;
            r_c_lo1 <= c_lo1;
            r_c_hi1 <= c_hi1;
            r_c_lo2 <= c_lo2;
            r_c_hi2 <= c_hi2;
            r_c_gap <= c_hit ? c_gap[sbc_pkg::GAP_BITS-1:0] : '0;

            r_d_idx <= r_c_idx;
            r_d_hit <= r_c_hit;
            r_d_gap <= r_c_gap;
            r_d_lo1 <= r_c_hit ? d_lo1[sbc_pkg::BOUND_BITS-1:0] : '0;
            r_d_hi1 <= r_c_hit ? d_hi1[sbc_pkg::BOUND_BITS-1:0] : '0;
            r_d_lo2 <= r_c_hit ? d_lo2[sbc_pkg::BOUND_BITS-1:0] : '0;
            r_d_hi2 <= r_c_hit ? d_hi2[sbc_pkg::BOUND_BITS-1:0] : '0;
        end
    end

    assign o_valid       = r_d_v;
    assign o_check_index = r_d_idx;
    assign o_hit         = r_d_hit;
    assign o_first_low   = r_d_lo1;
    assign o_first_high  = r_d_hi1;
    assign o_second_low  = r_d_lo2;
    assign o_second_high = r_d_hi2;
    assign o_gap         = r_d_gap;
    assign o_last        = (r_d_idx == sbc_pkg::CHECK_RIGHT_RF);

endmodule

// File: rtl/split_read_breakpoint_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split-read breakpoint check
// Runs the four neighbor checks on a forward/reverse alignment pair of one
// read and returns one result transaction per check.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Content
//  pair      in         i_valid / o_stall       read length, two alignments
//  result    out        o_valid / i_stall       index, hit, intervals, gap
//  config    in         psel/penable/pwrite     four threshold registers
//
//  A pair transaction yields four result transactions, one per cycle while
//  the result channel is not stalled; a new pair is taken as the last check
//  of the held pair issues, since the single result channel is fed from the
//  pair holding register. A pair's results pass stages A, B, C and D in turn.
//  Reset is synchronous and clears all valid bits and loads register defaults.
//  A stalled result freezes the whole pipeline and a busy holding register.
// ----------------------------------------------------------------------------
module split_read_breakpoint_check #(
    parameter int REF_COORD_BITS = 32,
    parameter int QRY_COORD_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sbc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [sbc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [sbc_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [QRY_COORD_BITS-1:0]         i_query_length,
    input  logic [REF_COORD_BITS-1:0]         i_fwd_ref_start,
    input  logic [REF_COORD_BITS-1:0]         i_fwd_ref_end,
    input  logic [QRY_COORD_BITS-1:0]         i_fwd_qry_start,
    input  logic [QRY_COORD_BITS-1:0]         i_fwd_qry_end,
    input  logic [REF_COORD_BITS-1:0]         i_rev_ref_start,
    input  logic [REF_COORD_BITS-1:0]         i_rev_ref_end,
    input  logic [QRY_COORD_BITS-1:0]         i_rev_qry_start,
    input  logic [QRY_COORD_BITS-1:0]         i_rev_qry_end,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_check_index,
    output logic                              o_hit,
    output logic [sbc_pkg::BOUND_BITS-1:0]    o_first_low,
    output logic [sbc_pkg::BOUND_BITS-1:0]    o_first_high,
    output logic [sbc_pkg::BOUND_BITS-1:0]    o_second_low,
    output logic [sbc_pkg::BOUND_BITS-1:0]    o_second_high,
    output logic [sbc_pkg::GAP_BITS-1:0]      o_gap,
    output logic                              o_last
);

    sbc_pkg::t_cfg              cfg;
    sbc_pkg::t_op_ctrl          op_ctrl;
    logic                       adv;
    logic [QRY_COORD_BITS-1:0]  op_q, a_qs, a_qe, b_qs, b_qe;
    logic [REF_COORD_BITS-1:0]  a_rs, a_re, b_rs, b_re;

    assign adv = !o_valid || !i_stall;

    sbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sbc_issue #(
        .RB (REF_COORD_BITS),
        .QB (QRY_COORD_BITS)
    ) u_issue (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_adv           (adv),
        .i_query_length  (i_query_length),
        .i_fwd_ref_start (i_fwd_ref_start),
        .i_fwd_ref_end   (i_fwd_ref_end),
        .i_fwd_qry_start (i_fwd_qry_start),
        .i_fwd_qry_end   (i_fwd_qry_end),
        .i_rev_ref_start (i_rev_ref_start),
        .i_rev_ref_end   (i_rev_ref_end),
        .i_rev_qry_start (i_rev_qry_start),
        .i_rev_qry_end   (i_rev_qry_end),
        .o_ctrl          (op_ctrl),
        .o_q             (op_q),
        .o_a_rs          (a_rs),
        .o_a_re          (a_re),
        .o_a_qs          (a_qs),
        .o_a_qe          (a_qe),
        .o_b_rs          (b_rs),
        .o_b_re          (b_re),
        .o_b_qs          (b_qs),
        .o_b_qe          (b_qe)
    );

    sbc_pipe #(
        .RB (REF_COORD_BITS),
        .QB (QRY_COORD_BITS)
    ) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_ctrl        (op_ctrl),
        .i_cfg         (cfg),
        .i_q           (op_q),
        .i_a_rs        (a_rs),
        .i_a_re        (a_re),
        .i_a_qs        (a_qs),
        .i_a_qe        (a_qe),
        .i_b_rs        (b_rs),
        .i_b_re        (b_re),
        .i_b_qs        (b_qs),
        .i_b_qe        (b_qe),
        .o_valid       (o_valid),
        .o_check_index (o_check_index),
        .o_hit         (o_hit),
        .o_first_low   (o_first_low),
        .o_first_high  (o_first_high),
        .o_second_low  (o_second_low),
        .o_second_high (o_second_high),
        .o_gap         (o_gap),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    a_last_on_final_check : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_check_index == sbc_pkg::CHECK_RIGHT_RF)
        else $error("last flag on a check other than the final one");

    a_miss_is_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_gap == '0 && o_first_low == '0 &&
                              o_first_high == '0 && o_second_low == '0 &&
                              o_second_high == '0)
        else $error("miss result carries nonzero interval or gap");

    a_check_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) ##1 o_valid |->
            o_check_index == 2'($past(o_check_index) + 2'd1))
        else $error("result transactions out of check order");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split-read breakpoint check testbench
// Sends forward/reverse alignment pairs through the pair channel and checks
// every result transaction against a local prediction of the four neighbor
// checks. It runs under the reset settings, extreme settings and several
// random settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int REF_BITS     = 32;
    localparam int QRY_BITS     = 24;
    localparam int BND_BITS     = sbc_pkg::BOUND_BITS;
    localparam int GP_BITS      = sbc_pkg::GAP_BITS;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [QRY_BITS-1:0] query_length;
        logic [REF_BITS-1:0] fwd_ref_start;
        logic [REF_BITS-1:0] fwd_ref_end;
        logic [QRY_BITS-1:0] fwd_qry_start;
        logic [QRY_BITS-1:0] fwd_qry_end;
        logic [REF_BITS-1:0] rev_ref_start;
        logic [REF_BITS-1:0] rev_ref_end;
        logic [QRY_BITS-1:0] rev_qry_start;
        logic [QRY_BITS-1:0] rev_qry_end;
    } t_pair;

    typedef struct {
        longint rs;
        longint re;
        longint qs;
        longint qe;
    } t_span;

    typedef struct packed {
        logic [1:0]          check_index;
        logic                hit;
        logic [BND_BITS-1:0] first_low;
        logic [BND_BITS-1:0] first_high;
        logic [BND_BITS-1:0] second_low;
        logic [BND_BITS-1:0] second_high;
        logic [GP_BITS-1:0]  gap;
        logic                last;
    } t_breakpoint;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [sbc_pkg::CFG_ADDR_BITS-1:0] paddr;
    logic [sbc_pkg::CFG_DATA_BITS-1:0] pwdata;
    logic [sbc_pkg::CFG_DATA_BITS-1:0] prdata;
    logic                              pready;
    logic                              i_valid;
    logic                              o_stall;
    t_pair                             pair_drv;
    logic                              o_valid;
    logic                              i_stall;
    logic [1:0]                        o_check_index;
    logic                              o_hit;
    logic [BND_BITS-1:0]               o_first_low;
    logic [BND_BITS-1:0]               o_first_high;
    logic [BND_BITS-1:0]               o_second_low;
    logic [BND_BITS-1:0]               o_second_high;
    logic [GP_BITS-1:0]                o_gap;
    logic                              o_last;

    logic [sbc_pkg::EXT_BITS-1:0]     cfg_min_ext;
    logic [sbc_pkg::MAX_GAP_BITS-1:0] cfg_max_gap;
    logic [sbc_pkg::OVL_BITS-1:0]     cfg_max_ovl;
    logic [sbc_pkg::TOL_BITS-1:0]     cfg_tol;

    t_breakpoint expected_checks[$];
    int          fail_count;
    int          pair_count;
    int          result_count;
    int          hit_count;
    int          setting_count;
    int          stall_left;
    bit          src_quiet;
    bit          sink_quiet;

    split_read_breakpoint_check #(
        .REF_COORD_BITS(REF_BITS),
        .QRY_COORD_BITS(QRY_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_query_length (pair_drv.query_length),
        .i_fwd_ref_start(pair_drv.fwd_ref_start),
        .i_fwd_ref_end  (pair_drv.fwd_ref_end),
        .i_fwd_qry_start(pair_drv.fwd_qry_start),
        .i_fwd_qry_end  (pair_drv.fwd_qry_end),
        .i_rev_ref_start(pair_drv.rev_ref_start),
        .i_rev_ref_end  (pair_drv.rev_ref_end),
        .i_rev_qry_start(pair_drv.rev_qry_start),
        .i_rev_qry_end  (pair_drv.rev_qry_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_check_index  (o_check_index),
        .o_hit          (o_hit),
        .o_first_low    (o_first_low),
        .o_first_high   (o_first_high),
        .o_second_low   (o_second_low),
        .o_second_high  (o_second_high),
        .o_gap          (o_gap),
        .o_last         (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint rnd(input longint lo, input longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    function automatic t_breakpoint neighbor_check(input logic [1:0] idx, input longint q,
                                                   input t_span a, input t_span b);
        t_breakpoint r;
        longint      ext, k, mg, ov, lim, d, lo1, hi1, lo2, hi2, g;
        logic        found;
        ext   = cfg_min_ext;
        k     = cfg_tol;
        mg    = cfg_max_gap;
        ov    = cfg_max_ovl;
        found = 1'b0;
        r     = '0;
        r.check_index = idx;
        r.last        = (idx == sbc_pkg::CHECK_RIGHT_RF);
        if (idx == sbc_pkg::CHECK_LEFT_FR || idx == sbc_pkg::CHECK_LEFT_RF) begin
            lim = q - b.qe;
            if (a.re + ext > b.re || a.qe + mg < lim) begin
                found = 1'b0;
            end else if (a.qe > lim) begin
                d = a.qe - lim;
                if (a.qe - a.qs >= d + ext && b.qe - b.qs >= d + ext &&
                    a.re + ext <= b.re - d && d <= ov) begin
                    found = 1'b1;
                    lo1 = a.re - d - k; hi1 = a.re + k;
                    lo2 = b.re - d - k; hi2 = b.re + k;
                    g   = -d;
                end
            end else begin
                d = lim - a.qe;
                found = 1'b1;
                lo1 = a.re - k; hi1 = a.re + d + k;
                lo2 = b.re - k; hi2 = b.re + d + k;
                g   = d;
            end
        end else begin
            lim = q - b.qs;
            if (a.rs + ext > b.rs || lim + mg < a.qs) begin
                found = 1'b0;
            end else if (lim > a.qs) begin
                d = lim - a.qs;
                if (a.qe - a.qs >= d + ext && b.qe - b.qs >= d + ext &&
                    a.rs + d + ext <= b.rs && d <= ov) begin
                    found = 1'b1;
                    lo1 = a.rs - k; hi1 = a.rs + d + k;
                    lo2 = b.rs - k; hi2 = b.rs + d + k;
                    g   = -d;
                end
            end else begin
                d = a.qs - lim;
                found = 1'b1;
                lo1 = a.rs - d - k; hi1 = a.rs + k;
                lo2 = b.rs - d - k; hi2 = b.rs + k;
                g   = d;
            end
        end
        if (found) begin
            r.hit         = 1'b1;
            r.first_low   = lo1[BND_BITS-1:0];
            r.first_high  = hi1[BND_BITS-1:0];
            r.second_low  = lo2[BND_BITS-1:0];
            r.second_high = hi2[BND_BITS-1:0];
            r.gap         = g[GP_BITS-1:0];
        end
        return r;
    endfunction

    task automatic expect_check(input t_breakpoint r);
        hit_count += r.hit;
        expected_checks.insert(expected_checks.size(), r);
    endtask

    task automatic predict_pair(input t_pair p);
        t_span  f, v;
        longint q;
        q    = p.query_length;
        f.rs = p.fwd_ref_start; f.re = p.fwd_ref_end;
        f.qs = p.fwd_qry_start; f.qe = p.fwd_qry_end;
        v.rs = p.rev_ref_start; v.re = p.rev_ref_end;
        v.qs = p.rev_qry_start; v.qe = p.rev_qry_end;
        expect_check(neighbor_check(sbc_pkg::CHECK_LEFT_FR, q, f, v));
        expect_check(neighbor_check(sbc_pkg::CHECK_LEFT_RF, q, v, f));
        expect_check(neighbor_check(sbc_pkg::CHECK_RIGHT_FR, q, f, v));
        expect_check(neighbor_check(sbc_pkg::CHECK_RIGHT_RF, q, v, f));
    endtask

    // Builds a pair aimed at one check with signed read distance s, where a
    // negative distance is an overlap. Slack around the limits is random.
    function automatic t_pair shaped_pair(input logic [1:0] target, input longint s);
        t_pair  p;
        longint ext, d, len_a, len_b, q, base, shift;
        longint a_rs, a_re, a_qs, a_qe, b_rs, b_re, b_qs, b_qe;
        ext   = cfg_min_ext;
        d     = (s < 0) ? -s : 0;
        len_a = d + ext + (($urandom_range(0, 3) == 0) ? rnd(-2, 2) : rnd(0, 300));
        len_b = d + ext + (($urandom_range(0, 3) == 0) ? rnd(-2, 2) : rnd(0, 300));
        q     = len_a + len_b + rnd(0, 5000);
        base  = ($urandom_range(0, 7) == 0) ? rnd(0, 100) : longint'($urandom);
        shift = ext + d + (($urandom_range(0, 3) == 0) ? rnd(-2, 2) : rnd(0, 100000));
        if (target == sbc_pkg::CHECK_LEFT_FR || target == sbc_pkg::CHECK_LEFT_RF) begin
            a_qe = len_a + rnd(0, 2000); a_qs = a_qe - len_a;
            b_qe = q - a_qe - s;         b_qs = b_qe - len_b;
            a_re = base;                 a_rs = a_re - len_a;
            b_re = a_re + shift;         b_rs = b_re - len_b;
        end else begin
            a_qs = rnd(0, 2000);         a_qe = a_qs + len_a;
            b_qs = q - a_qs + s;         b_qe = b_qs + len_b;
            a_rs = base;                 a_re = a_rs + len_a;
            b_rs = a_rs + shift;         b_re = b_rs + len_b;
        end
        p.query_length = q[QRY_BITS-1:0];
        if (target == sbc_pkg::CHECK_LEFT_FR || target == sbc_pkg::CHECK_RIGHT_FR) begin
            p.fwd_ref_start = a_rs[REF_BITS-1:0]; p.fwd_ref_end = a_re[REF_BITS-1:0];
            p.fwd_qry_start = a_qs[QRY_BITS-1:0]; p.fwd_qry_end = a_qe[QRY_BITS-1:0];
            p.rev_ref_start = b_rs[REF_BITS-1:0]; p.rev_ref_end = b_re[REF_BITS-1:0];
            p.rev_qry_start = b_qs[QRY_BITS-1:0]; p.rev_qry_end = b_qe[QRY_BITS-1:0];
        end else begin
            p.rev_ref_start = a_rs[REF_BITS-1:0]; p.rev_ref_end = a_re[REF_BITS-1:0];
            p.rev_qry_start = a_qs[QRY_BITS-1:0]; p.rev_qry_end = a_qe[QRY_BITS-1:0];
            p.fwd_ref_start = b_rs[REF_BITS-1:0]; p.fwd_ref_end = b_re[REF_BITS-1:0];
            p.fwd_qry_start = b_qs[QRY_BITS-1:0]; p.fwd_qry_end = b_qe[QRY_BITS-1:0];
        end
        return p;
    endfunction

    function automatic longint pick_distance();
        longint mg, ov;
        mg = cfg_max_gap;
        ov = cfg_max_ovl;
        case ($urandom_range(0, 7))
            0: return 0;
            1: return mg;
            2: return mg + 1;
            3: return -ov;
            4: return -ov - 1;
            5: return -rnd(1, (ov > 0) ? ov : 1);
            6: return rnd(0, mg + 50);
            default: return rnd(0, (mg < 3000) ? mg : 3000);
        endcase
    endfunction

    function automatic t_pair noise_pair();
        t_pair p;
        p.query_length  = $urandom; p.fwd_ref_start = $urandom;
        p.fwd_ref_end   = $urandom; p.fwd_qry_start = $urandom;
        p.fwd_qry_end   = $urandom; p.rev_ref_start = $urandom;
        p.rev_ref_end   = $urandom; p.rev_qry_start = $urandom;
        p.rev_qry_end   = $urandom;
        return p;
    endfunction

    function automatic t_pair random_pair();
        t_pair p, junk;
        p = shaped_pair(2'($urandom_range(0, 3)), pick_distance());
        case ($urandom_range(0, 19))
            0, 1, 2: p = noise_pair();
            3, 4, 5: begin
                junk = noise_pair();
                case ($urandom_range(0, 8))
                    0: p.query_length  = junk.query_length;
                    1: p.fwd_ref_start = junk.fwd_ref_start;
                    2: p.fwd_ref_end   = junk.fwd_ref_end;
                    3: p.fwd_qry_start = junk.fwd_qry_start;
                    4: p.fwd_qry_end   = junk.fwd_qry_end;
                    5: p.rev_ref_start = junk.rev_ref_start;
                    6: p.rev_ref_end   = junk.rev_ref_end;
                    7: p.rev_qry_start = junk.rev_qry_start;
                    default: p.rev_qry_end = junk.rev_qry_end;
                endcase
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pair(input t_pair p);
        int wait_cycles;
        wait_cycles = src_quiet ? 0 : $urandom_range(0, 11);
        @(negedge i_clk);
        if (wait_cycles > 0) begin
            i_valid <= 1'b0;
            repeat (wait_cycles) @(negedge i_clk);
        end
        pair_drv <= p;
        i_valid  <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pair_count++;
        predict_pair(p);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_checks.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [sbc_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sbc_pkg::REG_MIN_EXT:     cfg_min_ext = value[sbc_pkg::EXT_BITS-1:0];
            sbc_pkg::REG_MAX_GAP:     cfg_max_gap = value[sbc_pkg::MAX_GAP_BITS-1:0];
            sbc_pkg::REG_MAX_OVERLAP: cfg_max_ovl = value[sbc_pkg::OVL_BITS-1:0];
            default:                  cfg_tol     = value[sbc_pkg::TOL_BITS-1:0];
        endcase
    endtask

    // Bits above each register's width carry random junk that must be dropped.
    task automatic apply_settings(input longint ext, input longint mg, input longint ov,
                                  input longint tol);
        logic [sbc_pkg::CFG_DATA_BITS-1:0] junk;
        drain_results();
        junk = $urandom;
        write_reg(sbc_pkg::REG_MIN_EXT, {junk[31:16], ext[15:0]});
        write_reg(sbc_pkg::REG_MAX_GAP, {junk[31:20], mg[19:0]});
        write_reg(sbc_pkg::REG_MAX_OVERLAP, {junk[15:0], ov[15:0]});
        write_reg(sbc_pkg::REG_TOLERANCE, {junk[23:8], tol[15:0]});
        setting_count++;
    endtask

    task automatic test_default_settings();
        t_pair p;
        send_pair('0);
        send_pair('1);
        send_pair({31{8'hAA}});
        send_pair({31{8'h55}});
        for (int t = 0; t < 4; t++) begin
            send_pair(shaped_pair(2'(t), 7));
            send_pair(shaped_pair(2'(t), -20));
        end
        send_pair(shaped_pair(sbc_pkg::CHECK_LEFT_FR, cfg_max_gap));
        send_pair(shaped_pair(sbc_pkg::CHECK_LEFT_RF, longint'(cfg_max_gap) + 1));
        send_pair(shaped_pair(sbc_pkg::CHECK_RIGHT_FR, -longint'(cfg_max_ovl)));
        send_pair(shaped_pair(sbc_pkg::CHECK_RIGHT_RF, -longint'(cfg_max_ovl) - 1));
        p = shaped_pair(sbc_pkg::CHECK_LEFT_FR, 5);
        p.rev_qry_end   = p.query_length + 24'd77;
        p.fwd_qry_start = p.query_length + 24'd3;
        send_pair(p);
        p = shaped_pair(sbc_pkg::CHECK_RIGHT_RF, 0);
        p.fwd_qry_start = p.query_length + 24'd1000;
        send_pair(p);
    endtask

    task automatic test_extreme_settings();
        apply_settings(0, 0, 0, 0);
        for (int i = 0; i < 8; i++) send_pair(shaped_pair(2'(i % 4), -longint'(i % 2)));
        apply_settings(65535, 1048575, 65535, 65535);
        for (int i = 0; i < 8; i++) send_pair(shaped_pair(2'(i % 4), pick_distance()));
    endtask

    task automatic test_drained_pairs();
        src_quiet = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_pair(random_pair());
            drain_results();
        end
        src_quiet = 1'b0;
    endtask

    task automatic test_random_pairs();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: apply_settings(0, 1048575, 65535, 0);
                3: apply_settings(65535, 0, 0, 65535);
                default: apply_settings(rnd(0, 200), rnd(0, 2000), rnd(0, 100),
                                        rnd(0, 65535));
            endcase
            src_quiet  = (ph == 1) || (ph == 4);
            sink_quiet = (ph == 1) || (ph == 5);
            for (int i = 0; i < 53; i++) send_pair(random_pair());
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [BND_BITS-1:0] exp_val,
                                 input logic [BND_BITS-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %h, got %h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_breakpoint want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (expected_checks.size() == 0) begin
                $error("result transaction with no pending pair");
                fail_count++;
            end else begin
                want = expected_checks.pop_front();
                compare_field("check_index", BND_BITS'(want.check_index),
                              BND_BITS'(o_check_index));
                compare_field("hit", BND_BITS'(want.hit), BND_BITS'(o_hit));
                compare_field("first_low", want.first_low, o_first_low);
                compare_field("first_high", want.first_high, o_first_high);
                compare_field("second_low", want.second_low, o_second_low);
                compare_field("second_high", want.second_high, o_second_high);
                compare_field("gap", BND_BITS'(want.gap), BND_BITS'(o_gap));
                compare_field("last", BND_BITS'(want.last), BND_BITS'(o_last));
            end
            stall_left = sink_quiet ? 0 : $urandom_range(0, 11);
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= !sink_quiet && ($urandom_range(0, 15) == 0);
        end
    end

    initial begin
        #500000;
        $display("split_read_breakpoint_check test failed");
        $finish;
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        pair_drv      = '0;
        stall_left    = 0;
        src_quiet     = 1'b0;
        sink_quiet    = 1'b0;
        fail_count    = 0;
        pair_count    = 0;
        result_count  = 0;
        hit_count     = 0;
        setting_count = 1;
        cfg_min_ext   = sbc_pkg::RST_MIN_EXT;
        cfg_max_gap   = sbc_pkg::RST_MAX_GAP;
        cfg_max_ovl   = sbc_pkg::RST_MAX_OVERLAP;
        cfg_tol       = sbc_pkg::RST_TOLERANCE;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_settings();
        test_extreme_settings();
        test_drained_pairs();
        test_random_pairs();
        drain_results();

        $display("Checked %0d pairs and %0d result transactions (%0d hits expected)",
                 pair_count, result_count, hit_count);
        $display("across %0d register settings with random gaps and stalls.", setting_count);
        if (fail_count == 0) begin
            $display("split_read_breakpoint_check test passed");
        end else begin
            $display("split_read_breakpoint_check test failed");
        end
        $finish;
    end

endmodule
